[hw/rtl/ccs_pkg.sv]
// Shared types, note tables and microcode program of the clock chime scheduler.
package ccs_pkg;

  localparam int unsigned PcW    = 5;
  localparam int unsigned CountW = 4;

  typedef struct packed {
    logic [6:0] pitch;
    logic [2:0] hold;
  } note_t;

  typedef enum logic [1:0] {
    TYPE_WESTMINSTER = 2'd0,
    TYPE_WHITTINGTON = 2'd1,
    TYPE_ST_MICHAELS = 2'd2,
    TYPE_NONE        = 2'd3
  } chime_type_e;

  typedef enum logic [2:0] {
    SRC_CHANGE4 = 3'd0,
    SRC_CHANGE5 = 3'd1,
    SRC_QUARTER = 3'd2,
    SRC_DEEP    = 3'd3,
    SRC_HIGH    = 3'd4,
    SRC_HALF    = 3'd5
  } src_e;

  typedef enum logic [1:0] {
    PAUSE_0    = 2'd0,
    PAUSE_100  = 2'd1,
    PAUSE_500  = 2'd2,
    PAUSE_1000 = 2'd3
  } pause_e;

  typedef enum logic [1:0] {
    FLOW_NEXT = 2'd0,
    FLOW_LOOP = 2'd1,
    FLOW_END  = 2'd2
  } flow_e;

  typedef struct packed {
    src_e       src;
    logic [1:0] idx;
    pause_e     pause;
    flow_e      flow;
  } uword_t;

  typedef struct packed {
    logic       fire;
    src_e       src;
    logic [1:0] idx;
    pause_e     pause;
    logic       last;
  } ctrl_t;

  // program entry points
  localparam logic [PcW-1:0] PC_HOUR_WM   = 5'd0;
  localparam logic [PcW-1:0] PC_HOUR_TUNE = 5'd9;
  localparam logic [PcW-1:0] PC_HOUR_HIGH = 5'd13;
  localparam logic [PcW-1:0] PC_QUARTER   = 5'd14;
  localparam logic [PcW-1:0] PC_HALF      = 5'd18;

  localparam logic [6:0] PitchDeep  = 7'd57;
  localparam logic [6:0] PitchHigh  = 7'd72;
  localparam logic [6:0] PitchHalfW = 7'd64;

  localparam note_t TuneChange4 [4] = '{'{7'd68, 3'd1}, '{7'd64, 3'd1},
                                        '{7'd66, 3'd1}, '{7'd59, 3'd2}};
  localparam note_t TuneChange5 [4] = '{'{7'd59, 3'd1}, '{7'd66, 3'd1},
                                        '{7'd68, 3'd1}, '{7'd64, 3'd2}};
  localparam note_t TuneQtrW    [4] = '{'{7'd68, 3'd1}, '{7'd66, 3'd1},
                                        '{7'd64, 3'd1}, '{7'd59, 3'd2}};
  localparam note_t TuneQtrWh   [4] = '{'{7'd72, 3'd1}, '{7'd69, 3'd1},
                                        '{7'd65, 3'd1}, '{7'd60, 3'd2}};
  localparam note_t TuneQtrSm   [4] = '{'{7'd67, 3'd1}, '{7'd64, 3'd1},
                                        '{7'd60, 3'd1}, '{7'd67, 3'd2}};

  function automatic uword_t uw(src_e s, logic [1:0] i, pause_e p, flow_e f);
    uword_t w;
    w.src   = s;
    w.idx   = i;
    w.pause = p;
    w.flow  = f;
    return w;
  endfunction

  function automatic uword_t ccs_ucode(logic [PcW-1:0] pc);
    uword_t w;
    case (pc)
      5'd0:    w = uw(SRC_CHANGE4, 2'd0, PAUSE_100,  FLOW_NEXT);
      5'd1:    w = uw(SRC_CHANGE4, 2'd1, PAUSE_100,  FLOW_NEXT);
      5'd2:    w = uw(SRC_CHANGE4, 2'd2, PAUSE_100,  FLOW_NEXT);
      5'd3:    w = uw(SRC_CHANGE4, 2'd3, PAUSE_500,  FLOW_NEXT);
      5'd4:    w = uw(SRC_CHANGE5, 2'd0, PAUSE_100,  FLOW_NEXT);
      5'd5:    w = uw(SRC_CHANGE5, 2'd1, PAUSE_100,  FLOW_NEXT);
      5'd6:    w = uw(SRC_CHANGE5, 2'd2, PAUSE_100,  FLOW_NEXT);
      5'd7:    w = uw(SRC_CHANGE5, 2'd3, PAUSE_1000, FLOW_NEXT);
      5'd8:    w = uw(SRC_DEEP,    2'd0, PAUSE_1000, FLOW_LOOP);
      5'd9:    w = uw(SRC_QUARTER, 2'd0, PAUSE_100,  FLOW_NEXT);
      5'd10:   w = uw(SRC_QUARTER, 2'd1, PAUSE_100,  FLOW_NEXT);
      5'd11:   w = uw(SRC_QUARTER, 2'd2, PAUSE_100,  FLOW_NEXT);
      5'd12:   w = uw(SRC_QUARTER, 2'd3, PAUSE_500,  FLOW_NEXT);
      5'd13:   w = uw(SRC_HIGH,    2'd0, PAUSE_500,  FLOW_LOOP);
      5'd14:   w = uw(SRC_QUARTER, 2'd0, PAUSE_100,  FLOW_NEXT);
      5'd15:   w = uw(SRC_QUARTER, 2'd1, PAUSE_100,  FLOW_NEXT);
      5'd16:   w = uw(SRC_QUARTER, 2'd2, PAUSE_100,  FLOW_NEXT);
      5'd17:   w = uw(SRC_QUARTER, 2'd3, PAUSE_0,    FLOW_END);
      5'd18:   w = uw(SRC_HALF,    2'd0, PAUSE_0,    FLOW_END);
      default: w = uw(SRC_HALF,    2'd0, PAUSE_0,    FLOW_END);
    endcase
    return w;
  endfunction

  function automatic logic [9:0] ccs_pause_ms(pause_e p);
    logic [9:0] ms;
    case (p)
      PAUSE_0:    ms = 10'd0;
      PAUSE_100:  ms = 10'd100;
      PAUSE_500:  ms = 10'd500;
      PAUSE_1000: ms = 10'd1000;
      default:    ms = 10'd0;
    endcase
    return ms;
  endfunction

endpackage

[hw/rtl/ccs_seq.sv]
// Microcode sequencer: due test, repeat guard, step counter and strike loop.
module ccs_seq import ccs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [4:0]  hour_i,
  input  logic [5:0]  minute_i,
  input  logic [1:0]  chime_type_i,
  input  logic [2:0]  chime_rate_i,
  input  logic        out_free_i,
  output logic        in_ready_o,
  output ctrl_t       ctrl_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [PcW-1:0]    pc_q, pc_d;
  logic [CountW-1:0] count_q, count_d;
  logic [6:0]        last_min_q, last_min_d;
  logic [4:0]        last_hour_q, last_hour_d;

  uword_t            word;
  logic              accept, due, repeat_hit, fire, last_strike;
  logic              m_zero, m_15, m_30, m_45, m_60;
  logic [4:0]        hour_mod;
  logic [CountW-1:0] strikes;
  logic              start;
  logic [PcW-1:0]    entry;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_ready_o && in_valid_i;

  assign m_zero = (minute_i == 6'd0);
  assign m_15   = (minute_i == 6'd15);
  assign m_30   = (minute_i == 6'd30);
  assign m_45   = (minute_i == 6'd45);
  assign m_60   = (minute_i == 6'd60);

  assign due = (chime_rate_i[2] && (m_zero || m_15 || m_30 || m_45 || m_60))
            || ((chime_rate_i >= 3'd2) && (m_zero || m_30 || m_60))
            || ((chime_rate_i != 3'd0) && m_zero);

  assign repeat_hit = ({1'b0, minute_i} == last_min_q) && (hour_i == last_hour_q);

  // hour mod 12, zero meaning twelve
  always_comb begin
    if (hour_i >= 5'd24) begin
      hour_mod = hour_i - 5'd24;
    end else if (hour_i >= 5'd12) begin
      hour_mod = hour_i - 5'd12;
    end else begin
      hour_mod = hour_i;
    end
    strikes = (hour_mod == 5'd0) ? 4'd12 : hour_mod[CountW-1:0];
  end

  always_comb begin
    start = 1'b0;
    entry = PC_HALF;
    if (m_zero) begin
      start = 1'b1;
      case (chime_type_i)
        TYPE_WESTMINSTER: entry = PC_HOUR_WM;
        TYPE_NONE:        entry = PC_HOUR_HIGH;
        default:          entry = PC_HOUR_TUNE;
      endcase
    end else if (m_30) begin
      start = 1'b1;
      entry = PC_HALF;
    end else if (m_15 || m_45) begin
      start = (chime_type_i != TYPE_NONE);
      entry = PC_QUARTER;
    end
  end

  assign word        = ccs_ucode(pc_q);
  assign fire        = (state_q == ST_RUN) && out_free_i;
  assign last_strike = (count_q == 4'd1);

  always_comb begin
    ctrl_o.fire  = fire;
    ctrl_o.src   = word.src;
    ctrl_o.idx   = word.idx;
    ctrl_o.last  = (word.flow == FLOW_END) || ((word.flow == FLOW_LOOP) && last_strike);
    ctrl_o.pause = ctrl_o.last ? PAUSE_0 : word.pause;
  end

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    count_d     = count_q;
    last_min_d  = last_min_q;
    last_hour_d = last_hour_q;
    if (accept && due && !repeat_hit) begin
      last_min_d  = {1'b0, minute_i};
      last_hour_d = hour_i;
      pc_d        = entry;
      count_d     = strikes;
      if (start) begin
        state_d = ST_RUN;
      end
    end
    if (fire) begin
      case (word.flow)
        FLOW_NEXT: pc_d = pc_q + 1'b1;
        FLOW_LOOP: begin
          if (last_strike) begin
            state_d = ST_IDLE;
          end else begin
            count_d = count_q - 1'b1;
          end
        end
        default: state_d = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      count_q     <= '0;
      last_min_q  <= 7'd127;
      last_hour_q <= 5'd31;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      count_q     <= count_d;
      last_min_q  <= last_min_d;
      last_hour_q <= last_hour_d;
    end
  end

endmodule

[hw/rtl/ccs_dp.sv]
// Note datapath: tune lookup, pause decode and the output word register.
module ccs_dp import ccs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_t       ctrl_i,
  input  logic [1:0]  chime_type_i,
  input  logic        ready_i,
  output logic        out_free_o,
  output logic        valid_o,
  output logic [6:0]  pitch_o,
  output logic [2:0]  hold_o,
  output logic [9:0]  pause_o,
  output logic        last_o
);

  logic  valid_q, valid_d;
  note_t note_q, note_d;
  logic [9:0] pause_q, pause_d;
  logic  last_q, last_d;
  note_t note;

  always_comb begin
    case (ctrl_i.src)
      SRC_CHANGE4: note = TuneChange4[ctrl_i.idx];
      SRC_CHANGE5: note = TuneChange5[ctrl_i.idx];
      SRC_QUARTER: begin
        case (chime_type_i)
          TYPE_WHITTINGTON: note = TuneQtrWh[ctrl_i.idx];
          TYPE_ST_MICHAELS: note = TuneQtrSm[ctrl_i.idx];
          default:          note = TuneQtrW[ctrl_i.idx];
        endcase
      end
      SRC_DEEP: note = '{PitchDeep, 3'd4};
      SRC_HIGH: note = '{PitchHigh, 3'd2};
      default:  note = '{(chime_type_i == TYPE_WESTMINSTER) ? PitchHalfW : PitchHigh, 3'd4};
    endcase
  end

  assign out_free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    note_d  = note_q;
    pause_d = pause_q;
    last_d  = last_q;
    if (ctrl_i.fire) begin
      valid_d = 1'b1;
      note_d  = note;
      pause_d = ccs_pause_ms(ctrl_i.pause);
      last_d  = ctrl_i.last;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    note_q  <= note_d;
    pause_q <= pause_d;
    last_q  <= last_d;
  end

  assign valid_o = valid_q;
  assign pitch_o = note_q.pitch;
  assign hold_o  = note_q.hold;
  assign pause_o = pause_q;
  assign last_o  = last_q;

endmodule

[hw/rtl/clock_chime_scheduler.sv]
// Clock chime scheduler top level: configuration registers, sequencer and datapath.
//
// Input stream: one word per time sample, hour and minute. A sample that is due
// for the configured chime rate and differs from the last due pair starts a
// chime, except at minute 60 and at a quarter with type 3 (none); the output
// stream then carries one word per note, tlast on the final one. A chime has at
// most 20 notes, one microcode step per note, and the next sample is taken once
// the final note word has been loaded into the output register. The strike loop
// repeats one microcode step for 1 to 12 strikes.
// A note appears on the output in the cycle after its step. When the receiver
// stalls the output register holds its word and the sequencer waits on the same
// step; a new sample may be taken while the final note still waits.
// Reset empties the output register, returns the sequencer to idle, sets the
// type to 0 and the rate to 2, and forgets the last chimed pair.
// Registers via APB: chime_type at 0x0, chime_rate at 0x4.
module clock_chime_scheduler import ccs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // hour[4:0], minute[10:5], zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // pitch[6:0], hold_quarters[9:7], pause_after_ms[19:10]
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0] chime_type_q;
  logic [2:0] chime_rate_q;
  logic       cfg_wr;
  logic       out_free;
  ctrl_t      ctrl;
  logic [6:0] pitch;
  logic [2:0] hold;
  logic [9:0] pause;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = paddr[2] ? {29'd0, chime_rate_q} : {30'd0, chime_type_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chime_type_q <= TYPE_WESTMINSTER;
      chime_rate_q <= 3'd2;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        chime_rate_q <= pwdata[2:0];
      end else begin
        chime_type_q <= pwdata[1:0];
      end
    end
  end

  ccs_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .hour_i       (s_axis_tdata[4:0]),
    .minute_i     (s_axis_tdata[10:5]),
    .chime_type_i (chime_type_q),
    .chime_rate_i (chime_rate_q),
    .out_free_i   (out_free),
    .in_ready_o   (s_axis_tready),
    .ctrl_o       (ctrl)
  );

  ccs_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .chime_type_i (chime_type_q),
    .ready_i      (m_axis_tready),
    .out_free_o   (out_free),
    .valid_o      (m_axis_tvalid),
    .pitch_o      (pitch),
    .hold_o       (hold),
    .pause_o      (pause),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, pause, hold, pitch};

endmodule

[hw/rtl/ccs_chk.sv]
// Port-level assertions for the clock chime scheduler, bound to the top level.
module ccs_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  a_last_pause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[19:10] == 10'd0)
    else $error("final note carries a pause");

  a_pause_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[19:10] == 10'd0 || m_axis_tdata[19:10] == 10'd100
      || m_axis_tdata[19:10] == 10'd500 || m_axis_tdata[19:10] == 10'd1000)
    else $error("pause outside its set");

  a_deep_strike: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[6:0] == 7'd57 |-> m_axis_tdata[9:7] == 3'd4
      || m_axis_tdata[9:7] == 3'd2)
    else $error("note 57 with wrong hold");

endmodule

bind clock_chime_scheduler ccs_chk u_ccs_chk (.*);

[dv/tb_top.sv]
// Testbench for the clock chime scheduler: directed table, random time samples, note predictor.
`timescale 1ns / 100ps

module tb_top;
  import ccs_pkg::*;

  localparam int REG_CHIME_TYPE = 0;
  localparam int REG_CHIME_RATE = 1;

  localparam int TUNE_CHANGE4 = 3;
  localparam int TUNE_CHANGE5 = 4;

  localparam logic [6:0] BELL_DEEP   = 7'd57;
  localparam logic [6:0] BELL_HIGH   = 7'd72;
  localparam logic [6:0] BELL_HALF_W = 7'd64;

  // rows 0..2 follow the type code, then change 4 and change 5
  localparam logic [6:0] TUNE_PITCH [5][4] = '{
    '{7'd68, 7'd66, 7'd64, 7'd59},
    '{7'd72, 7'd69, 7'd65, 7'd60},
    '{7'd67, 7'd64, 7'd60, 7'd67},
    '{7'd68, 7'd64, 7'd66, 7'd59},
    '{7'd59, 7'd66, 7'd68, 7'd64}
  };

  typedef struct packed {
    logic [6:0] pitch;
    logic [2:0] hold;
    logic [9:0] pause;
    logic       last;
  } bell_note_t;

  typedef enum logic [1:0] {
    ROW_PREDICT = 2'd0,
    ROW_SILENT  = 2'd1,
    ROW_BELL    = 2'd2
  } row_kind_e;

  typedef struct packed {
    chime_type_e ctype;
    logic [2:0]  rate;
    logic [4:0]  hr;
    logic [5:0]  mn;
    row_kind_e   kind;
    logic [6:0]  bell;
  } plan_row_t;

  localparam plan_row_t CHIME_PLAN [23] = '{
    '{TYPE_WESTMINSTER, 3'd2, 5'd0,  6'd0,  ROW_PREDICT, 7'd0},
    '{TYPE_WESTMINSTER, 3'd2, 5'd0,  6'd0,  ROW_SILENT,  7'd0},
    '{TYPE_WESTMINSTER, 3'd2, 5'd0,  6'd15, ROW_SILENT,  7'd0},
    '{TYPE_WESTMINSTER, 3'd2, 5'd0,  6'd30, ROW_BELL,    7'd64},
    '{TYPE_WESTMINSTER, 3'd2, 5'd23, 6'd0,  ROW_PREDICT, 7'd0},
    '{TYPE_WHITTINGTON, 3'd7, 5'd12, 6'd15, ROW_PREDICT, 7'd0},
    '{TYPE_WHITTINGTON, 3'd7, 5'd12, 6'd45, ROW_PREDICT, 7'd0},
    '{TYPE_WHITTINGTON, 3'd7, 5'd31, 6'd60, ROW_SILENT,  7'd0},
    '{TYPE_WHITTINGTON, 3'd7, 5'd31, 6'd60, ROW_SILENT,  7'd0},
    '{TYPE_WHITTINGTON, 3'd7, 5'd31, 6'd0,  ROW_PREDICT, 7'd0},
    '{TYPE_WHITTINGTON, 3'd7, 5'd5,  6'd63, ROW_SILENT,  7'd0},
    '{TYPE_WHITTINGTON, 3'd7, 5'd5,  6'd30, ROW_BELL,    7'd72},
    '{TYPE_ST_MICHAELS, 3'd4, 5'd11, 6'd15, ROW_PREDICT, 7'd0},
    '{TYPE_ST_MICHAELS, 3'd4, 5'd11, 6'd0,  ROW_PREDICT, 7'd0},
    '{TYPE_NONE,        3'd3, 5'd12, 6'd0,  ROW_PREDICT, 7'd0},
    '{TYPE_NONE,        3'd3, 5'd12, 6'd15, ROW_SILENT,  7'd0},
    '{TYPE_NONE,        3'd3, 5'd12, 6'd30, ROW_BELL,    7'd72},
    '{TYPE_NONE,        3'd5, 5'd13, 6'd45, ROW_SILENT,  7'd0},
    '{TYPE_WESTMINSTER, 3'd1, 5'd1,  6'd30, ROW_SILENT,  7'd0},
    '{TYPE_WESTMINSTER, 3'd1, 5'd1,  6'd0,  ROW_PREDICT, 7'd0},
    '{TYPE_WESTMINSTER, 3'd0, 5'd2,  6'd0,  ROW_SILENT,  7'd0},
    '{TYPE_WESTMINSTER, 3'd4, 5'd3,  6'd15, ROW_PREDICT, 7'd0},
    '{TYPE_WESTMINSTER, 3'd4, 5'd16, 6'd31, ROW_SILENT,  7'd0}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  chime_type_e cfg_type  = TYPE_WESTMINSTER;
  logic [2:0]  cfg_rate  = 3'd2;
  logic [6:0]  last_min  = 7'd127;
  logic [4:0]  last_hour = 5'd31;

  bell_note_t chime_notes [$];
  bell_note_t notes_due [$];
  int         mismatches   = 0;
  bit         idle_on      = 1'b1;
  bit         hold_off_req = 1'b0;

  clock_chime_scheduler DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic void add_note(logic [6:0] pitch, logic [2:0] hold, logic [9:0] pause);
    chime_notes.push_back('{pitch, hold, pause, 1'b0});
  endfunction

  function automatic void add_tune(int which, logic [9:0] tail);
    for (int i = 0; i < 4; i++) begin
      add_note(TUNE_PITCH[which][i], (i == 3) ? 3'd2 : 3'd1, (i < 3) ? 10'd100 : tail);
    end
  endfunction

  function automatic void add_strikes(logic [4:0] hr, logic [6:0] pitch, logic [2:0] hold,
                                      logic [9:0] gap);
    int n;
    n = hr % 12;
    if (n == 0) n = 12;
    for (int i = 0; i < n; i++) begin
      add_note(pitch, hold, (i + 1 < n) ? gap : 10'd0);
    end
  endfunction

  // fills chime_notes; returns 1 when the sample is due and not a repeat
  function automatic bit chime_predict(logic [4:0] hr, logic [5:0] mn);
    bit due;
    chime_notes = {};
    due = (cfg_rate >= 3'd4 && mn % 15 == 0) || (cfg_rate >= 3'd2 && mn % 30 == 0) ||
          (cfg_rate >= 3'd1 && mn == 0);
    if (!due || ({1'b0, mn} == last_min && hr == last_hour)) return 1'b0;
    if (mn == 0) begin
      if (cfg_type == TYPE_WESTMINSTER) begin
        add_tune(TUNE_CHANGE4, 10'd500);
        add_tune(TUNE_CHANGE5, 10'd1000);
        add_strikes(hr, BELL_DEEP, 3'd4, 10'd1000);
      end else begin
        if (cfg_type != TYPE_NONE) add_tune(int'(cfg_type), 10'd500);
        add_strikes(hr, BELL_HIGH, 3'd2, 10'd500);
      end
    end else if (mn == 30) begin
      add_note((cfg_type == TYPE_WESTMINSTER) ? BELL_HALF_W : BELL_HIGH, 3'd4, 10'd0);
    end else if ((mn == 15 || mn == 45) && cfg_type != TYPE_NONE) begin
      add_tune(int'(cfg_type), 10'd0);
    end
    if (chime_notes.size() != 0) chime_notes[chime_notes.size() - 1].last = 1'b1;
    last_min  = {1'b0, mn};
    last_hour = hr;
    return 1'b1;
  endfunction

  task automatic apb_write(input int idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(idx * 4);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_CHIME_TYPE: cfg_type = chime_type_e'(val[1:0]);
      REG_CHIME_RATE: cfg_rate = val[2:0];
      default: ;
    endcase
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (notes_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic present_sample(input logic [4:0] hr, input logic [5:0] mn);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, mn, hr};
    do @(posedge clk_i); while (!s_axis_tready);
    void'(chime_predict(hr, mn));
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    bell_note_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (notes_due.size() == 0) begin
        $error("note word with nothing expected: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
        mismatches++;
      end else begin
        want = notes_due.pop_front();
        if (m_axis_tdata[6:0] != want.pitch) begin
          $error("pitch: expected %0d, actual %0d", want.pitch, m_axis_tdata[6:0]);
          mismatches++;
        end
        if (m_axis_tdata[9:7] != want.hold) begin
          $error("hold_quarters: expected %0d, actual %0d", want.hold, m_axis_tdata[9:7]);
          mismatches++;
        end
        if (m_axis_tdata[19:10] != want.pause) begin
          $error("pause_after_ms: expected %0d, actual %0d", want.pause, m_axis_tdata[19:10]);
          mismatches++;
        end
        if (m_axis_tlast != want.last) begin
          $error("last_note: expected %0d, actual %0d", want.last, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int counted;
    int phase;
    int pick;
    int wh;
    int wm;
    counted = 0;
    phase   = 0;
    wh      = 0;
    wm      = 0;
    repeat (5) @(posedge clk_i);

    foreach (CHIME_PLAN[i]) begin
      if (CHIME_PLAN[i].ctype != cfg_type || CHIME_PLAN[i].rate != cfg_rate) begin
        settle();
        apb_write(REG_CHIME_TYPE, 32'(CHIME_PLAN[i].ctype));
        apb_write(REG_CHIME_RATE, 32'(CHIME_PLAN[i].rate));
      end
      present_sample(CHIME_PLAN[i].hr, CHIME_PLAN[i].mn);
      case (CHIME_PLAN[i].kind)
        ROW_PREDICT: notes_due = {notes_due, chime_notes};
        ROW_BELL:    notes_due.push_back('{CHIME_PLAN[i].bell, 3'd4, 10'd0, 1'b1});
        default: ;
      endcase
    end

    while (counted < 480) begin
      settle();
      apb_write(REG_CHIME_TYPE, $urandom_range(0, 3));
      apb_write(REG_CHIME_RATE, $urandom_range(1, 7));
      idle_on = (counted < 420) && (phase % 3 != 1);
      if (phase == 2) hold_off_req = 1'b1;
      repeat (60) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          // clock walking forward one quarter at a time
          wm = (wm / 15 + 1) * 15;
          if (wm >= 60) begin
            wm = 0;
            wh = (wh + 1) % 24;
          end
        end else if (pick < 7) begin
          wh = ($urandom_range(0, 7) == 0) ? $urandom_range(24, 31) : $urandom_range(0, 23);
          wm = 15 * $urandom_range(0, 4);
        end else if (pick > 7) begin
          wh = $urandom_range(0, 31);
          wm = $urandom_range(0, 63);
        end
        present_sample(5'(wh), 6'(wm));
        counted++;
        notes_due = {notes_due, chime_notes};
      end
      phase++;
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
